// ===== hdl/lswfs_pkg.sv =====
// Shared constants, types and helpers for the laser sector wall-follow steering block.
`default_nettype none

package lswfs_pkg;

  // Scan geometry
  localparam int NUM_SECTORS    = 12;
  localparam int HALF_BEAM      = 10;
  localparam int BEAMS_PER_SCAN = 360;

  // Width of a beam offset before the wrap fold (up to twice the scan length)
  localparam int DW = $clog2(2 * BEAMS_PER_SCAN);

  // Named sectors
  localparam int SEC_FRONT  = 0;
  localparam int SEC_LFRONT = NUM_SECTORS / 6;
  localparam int SEC_LEFT   = NUM_SECTORS / 4;
  localparam int SEC_BACK   = NUM_SECTORS / 2;
  localparam int SEC_RIGHT  = NUM_SECTORS * 3 / 4;

  // Field widths
  localparam int RW  = 16;  // distances and ranges
  localparam int BW  = 9;   // beam index
  localparam int LW  = 10;  // linear speed
  localparam int AW  = 12;  // angular speed magnitude
  localparam int SAW = 13;  // signed angular speed
  localparam int CW  = 3;   // cause code
  localparam int QD  = 4;   // commands per tick at most
  localparam int QCW = $clog2(QD + 1);

  // Input item kinds
  localparam logic OP_BEAM = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Command causes
  localparam logic [CW-1:0] CAUSE_STOP_OBST  = 3'd0;
  localparam logic [CW-1:0] CAUSE_STOP_START = 3'd1;
  localparam logic [CW-1:0] CAUSE_LEFT_FAR   = 3'd2;
  localparam logic [CW-1:0] CAUSE_LEFT_NEAR  = 3'd3;
  localparam logic [CW-1:0] CAUSE_FRONT      = 3'd4;
  localparam logic [CW-1:0] CAUSE_CLEAR      = 3'd5;
  localparam logic [CW-1:0] CAUSE_RIGHT_NEAR = 3'd6;
  localparam logic [CW-1:0] CAUSE_REAR       = 3'd7;

  // Configuration register indexes
  localparam logic [2:0] REG_RANGE_LIMIT = 3'd0;
  localparam logic [2:0] REG_SAFE_DIST   = 3'd1;
  localparam logic [2:0] REG_FOLLOW_DIST = 3'd2;
  localparam logic [2:0] REG_WARN_DIST   = 3'd3;
  localparam logic [2:0] REG_MAX_LIN     = 3'd4;
  localparam logic [2:0] REG_MAX_ANG     = 3'd5;

  // One speed command
  typedef struct packed {
    logic [CW-1:0]         cause;
    logic signed [SAW-1:0] ang;
    logic [LW-1:0]         lin;
  } cmd_t;

  // Centre beam of a sector
  function automatic logic [DW-1:0] sec_center(input int s);
    int c;
    begin
      c = s * BEAMS_PER_SCAN / NUM_SECTORS;
      return DW'(c);
    end
  endfunction

  // Floor of x/10 for x below 43690, by reciprocal multiply
  function automatic logic [14:0] div10(input logic [14:0] x);
    logic [30:0] p;
    begin
      p = 31'(x) * 31'd52429;
      return p[30:19] == 12'd0 ? 15'd0 : 15'(p[30:19]);
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/laser_sector_wall_follow_steer.sv =====
// Top level: laser sector minima and reactive left-wall steering commands.
//
// Input stream (in_*): one item per handshake. in_tuser[0] is the kind (0 beam
// sample, 1 control tick), in_tuser[1] restarts the working minima, in_tlast
// on a beam item publishes them as sector distances. Beam items give no results.
// Output stream (out_*): speed commands; out_tlast marks the last command of
// a tick, out_tuser carries the cause code.
// Config port (cfg_*): register writes, always ready, applied at the handshake.
//
// Flow: an item is taken into an input register and handled from there; a tick
// waits there until the output queue can take it. A beam item updates the minima
// in the cycle after acceptance; a tick's commands are offered from the queue.
// Throughput: one beam item per cycle unless a tick waits in the input register.
// A tick puts 1 to 4 commands into a four-entry output queue that drains one
// command per cycle while the receiver is ready; the next tick waits until the
// queue is empty or its last command is taken. Beams flow while the queue drains.
// Reset: configuration returns to its defaults, published sector distances
// clear to zero, input register and output queue empty. When the receiver
// stalls, the queue holds, and a following tick waits in the input register
// with in_tready low.
`default_nettype none

module laser_sector_wall_follow_steer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [8:0] beam_index, [24:9] beam_range, [25] at_start
  input  wire logic [1:0]  in_tuser,   // [0] op, [1] scan_first
  input  wire logic        in_tlast,   // scan_last
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [9:0] lin_speed, [22:10] ang_speed
  output logic [2:0]       out_tuser,  // [2:0] cause
  output logic             out_tlast,  // last_cmd
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  localparam int NS = lswfs_pkg::NUM_SECTORS;
  localparam int RW = lswfs_pkg::RW;
  localparam int DW = lswfs_pkg::DW;
  localparam int QD = lswfs_pkg::QD;

  // Configuration registers
  logic [RW-1:0]             range_limit_r, safe_dist_r, follow_dist_r, warn_dist_r;
  logic [lswfs_pkg::LW-1:0]  max_lin_r;
  logic [lswfs_pkg::AW-1:0]  max_ang_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_limit_r <= 16'd3500;
      safe_dist_r   <= 16'd100;
      follow_dist_r <= 16'd300;
      warn_dist_r   <= 16'd600;
      max_lin_r     <= 10'd100;
      max_ang_r     <= 12'd1500;
    end else if (cfg_valid) begin
      case (cfg_addr)
        lswfs_pkg::REG_RANGE_LIMIT: range_limit_r <= cfg_wdata;
        lswfs_pkg::REG_SAFE_DIST:   safe_dist_r   <= cfg_wdata;
        lswfs_pkg::REG_FOLLOW_DIST: follow_dist_r <= cfg_wdata;
        lswfs_pkg::REG_WARN_DIST:   warn_dist_r   <= cfg_wdata;
        lswfs_pkg::REG_MAX_LIN:     max_lin_r     <= cfg_wdata[lswfs_pkg::LW-1:0];
        lswfs_pkg::REG_MAX_ANG:     max_ang_r     <= cfg_wdata[lswfs_pkg::AW-1:0];
        default: ;
      endcase
    end
  end

  // Speed fractions, refreshed every cycle from the registers
  logic [lswfs_pkg::LW-1:0] lin4_r, lin2_r;
  logic [lswfs_pkg::AW-1:0] ang2_r, ang3_r, ang5_r;
  logic [14:0]              lin4_q, lin2_q, ang2_q, ang3_q, ang5_q;

  assign lin4_q = lswfs_pkg::div10(15'({max_lin_r, 2'b00}));
  assign lin2_q = lswfs_pkg::div10(15'({max_lin_r, 1'b0}));
  assign ang2_q = lswfs_pkg::div10(15'({max_ang_r, 1'b0}));
  assign ang3_q = lswfs_pkg::div10(15'({max_ang_r, 1'b0}) + 15'(max_ang_r));
  assign ang5_q = lswfs_pkg::div10(15'({max_ang_r, 2'b00}) + 15'(max_ang_r));

  always_ff @(posedge clk) begin
    lin4_r <= lin4_q[lswfs_pkg::LW-1:0];
    lin2_r <= lin2_q[lswfs_pkg::LW-1:0];
    ang2_r <= ang2_q[lswfs_pkg::AW-1:0];
    ang3_r <= ang3_q[lswfs_pkg::AW-1:0];
    ang5_r <= ang5_q[lswfs_pkg::AW-1:0];
  end

  // Input register
  logic                     ivld_r;
  logic                     op_r, first_r, last_r, at_start_r;
  logic [lswfs_pkg::BW-1:0] beam_r;
  logic [RW-1:0]            range_r;
  logic                     advance, buf_free, in_acc, out_pop;

  logic [lswfs_pkg::QCW-1:0] rem_r, rem_nxt;
  lswfs_pkg::cmd_t           q_r [QD];

  assign out_tvalid = (rem_r != '0);
  assign out_pop    = out_tvalid && out_tready;
  assign buf_free   = (rem_r == '0) || ((rem_r == lswfs_pkg::QCW'(1)) && out_tready);
  assign advance    = ivld_r && ((op_r == lswfs_pkg::OP_BEAM) || buf_free);
  assign in_tready  = !ivld_r || advance;
  assign in_acc     = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r <= 1'b0;
    end else if (in_acc) begin
      ivld_r <= 1'b1;
    end else if (advance) begin
      ivld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r       <= in_tuser[0];
      first_r    <= in_tuser[1];
      last_r     <= in_tlast;
      beam_r     <= in_tdata[8:0];
      range_r    <= in_tdata[24:9];
      at_start_r <= in_tdata[25];
    end
  end

  // Sector minima fold for a beam item
  logic [RW-1:0] work_min_r    [NS];
  logic [RW-1:0] sector_dist_r [NS];
  logic [RW-1:0] fold          [NS];

  always_comb begin
    logic [DW-1:0] d;
    logic [RW-1:0] base;
    logic          hit;
    for (int s = 0; s < NS; s++) begin
      d = DW'(beam_r) + DW'(lswfs_pkg::BEAMS_PER_SCAN) - lswfs_pkg::sec_center(s);
      if (d >= DW'(lswfs_pkg::BEAMS_PER_SCAN)) begin
        d = d - DW'(lswfs_pkg::BEAMS_PER_SCAN);
      end
      hit = (DW'(beam_r) < DW'(lswfs_pkg::BEAMS_PER_SCAN)) &&
            ((d < DW'(lswfs_pkg::HALF_BEAM)) ||
             (d >= DW'(lswfs_pkg::BEAMS_PER_SCAN - lswfs_pkg::HALF_BEAM)));
      base = first_r ? range_limit_r : work_min_r[s];
      fold[s] = (hit && (range_r < base)) ? range_r : base;
    end
  end

  // Working minima have no reset; published distances clear to zero
  always_ff @(posedge clk) begin
    if (advance && (op_r == lswfs_pkg::OP_BEAM)) begin
      for (int s = 0; s < NS; s++) begin
        work_min_r[s] <= fold[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS; s++) begin
        sector_dist_r[s] <= '0;
      end
    end else if (advance && (op_r == lswfs_pkg::OP_BEAM) && last_r) begin
      for (int s = 0; s < NS; s++) begin
        sector_dist_r[s] <= fold[s];
      end
    end
  end

  // Tick rules: build the command list
  lswfs_pkg::cmd_t           tick_q [QD];
  logic [lswfs_pkg::QCW-1:0] tick_n;

  always_comb begin
    logic                        any_stop;
    logic [lswfs_pkg::LW-1:0]    lin;
    logic                        left_ok, lfront_ok;
    logic [RW-1:0]               left, right;
    lswfs_pkg::cmd_t             c;
    any_stop  = 1'b0;
    for (int s = 0; s < NS; s++) begin
      any_stop = any_stop || (sector_dist_r[s] < safe_dist_r);
    end
    left      = sector_dist_r[lswfs_pkg::SEC_LEFT];
    right     = sector_dist_r[lswfs_pkg::SEC_RIGHT];
    left_ok   = (left >= follow_dist_r);
    lfront_ok = (sector_dist_r[lswfs_pkg::SEC_LFRONT] >= follow_dist_r);
    for (int k = 0; k < QD; k++) begin
      tick_q[k] = '0;
    end
    tick_n = '0;
    c      = '0;
    lin    = '0;

    if (any_stop) begin
      tick_q[0].cause = lswfs_pkg::CAUSE_STOP_OBST;
      tick_n = lswfs_pkg::QCW'(1);
    end else if (at_start_r) begin
      tick_q[0].cause = lswfs_pkg::CAUSE_STOP_START;
      tick_n = lswfs_pkg::QCW'(1);
    end else begin
      // left pair
      if (left_ok && lfront_ok) begin
        c.lin   = lin4_r;
        c.ang   = $signed({1'b0, ang2_r});
        c.cause = lswfs_pkg::CAUSE_LEFT_FAR;
        tick_q[tick_n[1:0]] = c;
        tick_n = tick_n + lswfs_pkg::QCW'(1);
      end else if (!left_ok && !lfront_ok) begin
        c.lin   = lin2_r;
        c.ang   = -$signed({1'b0, ang3_r});
        c.cause = lswfs_pkg::CAUSE_LEFT_NEAR;
        tick_q[tick_n[1:0]] = c;
        tick_n = tick_n + lswfs_pkg::QCW'(1);
      end
      // front step, always one command
      if (sector_dist_r[lswfs_pkg::SEC_FRONT] < warn_dist_r) begin
        lin     = lin4_r;
        c.ang   = -$signed({1'b0, max_ang_r});
        c.cause = lswfs_pkg::CAUSE_FRONT;
      end else begin
        lin     = lin2_r;
        c.ang   = '0;
        c.cause = lswfs_pkg::CAUSE_CLEAR;
      end
      c.lin = lin;
      tick_q[tick_n[1:0]] = c;
      tick_n = tick_n + lswfs_pkg::QCW'(1);
      // right near, shadowed by the obstacle stop
      if (right < safe_dist_r) begin
        c.lin   = lin;
        c.ang   = $signed({1'b0, ang5_r});
        c.cause = lswfs_pkg::CAUSE_RIGHT_NEAR;
        tick_q[tick_n[1:0]] = c;
        tick_n = tick_n + lswfs_pkg::QCW'(1);
      end
      // rear obstacle: turn toward the more open side
      if (sector_dist_r[lswfs_pkg::SEC_BACK] < follow_dist_r) begin
        c.lin   = lin;
        c.ang   = (left > right) ? $signed({1'b0, ang5_r}) : -$signed({1'b0, ang5_r});
        c.cause = lswfs_pkg::CAUSE_REAR;
        tick_q[tick_n[1:0]] = c;
        tick_n = tick_n + lswfs_pkg::QCW'(1);
      end
    end
  end

  // Output queue: load a tick's commands, shift out one per pop
  logic tick_load;
  assign tick_load = advance && (op_r == lswfs_pkg::OP_TICK);

  always_comb begin
    rem_nxt = rem_r;
    if (tick_load) begin
      rem_nxt = tick_n;
    end else if (out_pop) begin
      rem_nxt = rem_r - lswfs_pkg::QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_load) begin
      for (int k = 0; k < QD; k++) begin
        q_r[k] <= tick_q[k];
      end
    end else if (out_pop) begin
      for (int k = 0; k < QD - 1; k++) begin
        q_r[k] <= q_r[k+1];
      end
    end
  end

  assign out_tdata = {1'b0, q_r[0].ang, q_r[0].lin};
  assign out_tuser = q_r[0].cause;
  assign out_tlast = (rem_r == lswfs_pkg::QCW'(1));

  // Checks
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= lswfs_pkg::QCW'(QD))
    else $error("output queue count beyond depth");

  a_stop_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && ((out_tuser == lswfs_pkg::CAUSE_STOP_OBST) ||
                    (out_tuser == lswfs_pkg::CAUSE_STOP_START))) |-> out_tlast)
    else $error("stop command is not the only command of its tick");

  a_tick_held: assert property (@(posedge clk) disable iff (!rst_n)
    (ivld_r && (op_r == lswfs_pkg::OP_TICK) && !buf_free) |=>
      (ivld_r && (op_r == lswfs_pkg::OP_TICK)))
    else $error("blocked tick lost from input register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready && !out_tlast) |-> !tick_load)
    else $error("tick loaded over pending commands");

endmodule

`default_nettype wire

// ===== sim/steer_checker.sv =====
// Checker for the wall-follow steering block: tracks config and sector state, predicts commands.
`timescale 1ns / 100ps

module steer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [8:0] beam_index, [24:9] beam_range, [25] at_start
  input  logic [1:0]  in_tuser,   // [0] op, [1] scan_first
  input  logic        in_tlast,   // scan_last
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [9:0] lin_speed, [22:10] ang_speed
  input  logic [2:0]  out_tuser,  // [2:0] cause
  input  logic        out_tlast,  // last_cmd
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          cmds_due
);
  import lswfs_pkg::*;

  typedef struct packed {
    logic last;
    cmd_t cmd;
  } steer_cmd_t;

  // Shadow configuration
  logic [RW-1:0] lim_range, d_safe, d_follow, d_warn;
  logic [LW-1:0] lin_max;
  logic [AW-1:0] ang_max;

  // Working minima of the current scan and the published distances
  logic [RW-1:0] scan_min [NUM_SECTORS];
  logic [RW-1:0] published [NUM_SECTORS];

  steer_cmd_t cmds_expected [$];
  int mismatches = 0;

  assign fail_count = mismatches;

  // Truncated k/10 of a maximum speed
  function automatic int tenth_of(input int v, input int k);
    return v * k / 10;
  endfunction

  function automatic void queue_cmd(input int lin, input int mag, input bit neg,
                                    input logic [CW-1:0] why);
    steer_cmd_t c;
    c.last      = 1'b0;
    c.cmd.lin   = LW'(lin);
    c.cmd.ang   = neg ? -SAW'(mag) : SAW'(mag);
    c.cmd.cause = why;
    cmds_expected.push_back(c);
  endfunction

  // Fold one beam into the sector minima, restart and publish on the flags
  function automatic void fold_beam(input logic [BW-1:0] idx, input logic [RW-1:0] rng,
                                    input logic first, input logic last);
    int s, ctr, gap;
    if (first)
      for (s = 0; s < NUM_SECTORS; s++) scan_min[s] = lim_range;
    if (idx < BEAMS_PER_SCAN) begin
      for (s = 0; s < NUM_SECTORS; s++) begin
        ctr = s * BEAMS_PER_SCAN / NUM_SECTORS;
        gap = (int'(idx) + BEAMS_PER_SCAN - ctr) % BEAMS_PER_SCAN;
        if ((gap < HALF_BEAM || gap >= BEAMS_PER_SCAN - HALF_BEAM) && rng < scan_min[s])
          scan_min[s] = rng;
      end
    end
    if (last)
      for (s = 0; s < NUM_SECTORS; s++) published[s] = scan_min[s];
  endfunction

  // Stop rules first, then left pair, front, right and rear steps
  function automatic void predict_tick(input logic back_home);
    bit blocked;
    int cnt, lin, s;
    logic [RW-1:0] left, right;
    steer_cmd_t tail;
    blocked = 1'b0;
    for (s = 0; s < NUM_SECTORS; s++)
      if (published[s] < d_safe) blocked = 1'b1;
    if (blocked) begin
      queue_cmd(0, 0, 1'b0, CAUSE_STOP_OBST);
    end else if (back_home) begin
      queue_cmd(0, 0, 1'b0, CAUSE_STOP_START);
    end else begin
      left  = published[SEC_LEFT];
      right = published[SEC_RIGHT];
      cnt   = 0;
      if (left >= d_follow) cnt++;
      if (published[SEC_LFRONT] >= d_follow) cnt++;
      if (cnt == 2)
        queue_cmd(tenth_of(lin_max, 4), tenth_of(ang_max, 2), 1'b0, CAUSE_LEFT_FAR);
      else if (cnt == 0)
        queue_cmd(tenth_of(lin_max, 2), tenth_of(ang_max, 3), 1'b1, CAUSE_LEFT_NEAR);
      if (published[SEC_FRONT] < d_warn) begin
        lin = tenth_of(lin_max, 4);
        queue_cmd(lin, ang_max, 1'b1, CAUSE_FRONT);
      end else begin
        lin = tenth_of(lin_max, 2);
        queue_cmd(lin, 0, 1'b0, CAUSE_CLEAR);
      end
      // cannot fire past the obstacle stop, still modeled
      if (right < d_safe)
        queue_cmd(lin, tenth_of(ang_max, 5), 1'b0, CAUSE_RIGHT_NEAR);
      if (published[SEC_BACK] < d_follow)
        queue_cmd(lin, tenth_of(ang_max, 5), !(left > right), CAUSE_REAR);
    end
    tail = cmds_expected.pop_back();
    tail.last = 1'b1;
    cmds_expected.push_back(tail);
  endfunction

  // Watch all three channels at each edge
  always @(posedge clk) begin : watch
    steer_cmd_t want;
    if (!rst_n) begin
      lim_range = 16'd3500;
      d_safe    = 16'd100;
      d_follow  = 16'd300;
      d_warn    = 16'd600;
      lin_max   = 10'd100;
      ang_max   = 12'd1500;
      foreach (published[s]) begin
        published[s] = '0;
        scan_min[s]  = '0;
      end
      cmds_expected.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_RANGE_LIMIT: lim_range = cfg_wdata;
          REG_SAFE_DIST:   d_safe    = cfg_wdata;
          REG_FOLLOW_DIST: d_follow  = cfg_wdata;
          REG_WARN_DIST:   d_warn    = cfg_wdata;
          REG_MAX_LIN:     lin_max   = cfg_wdata[LW-1:0];
          REG_MAX_ANG:     ang_max   = cfg_wdata[AW-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == OP_TICK)
          predict_tick(in_tdata[25]);
        else
          fold_beam(in_tdata[8:0], in_tdata[24:9], in_tuser[1], in_tlast);
      end
      if (out_tvalid && out_tready) begin
        if (cmds_expected.size() == 0) begin
          $error("command with none expected: lin %0d ang %0d cause %0d",
                 out_tdata[9:0], $signed(out_tdata[22:10]), out_tuser);
          mismatches++;
        end else begin
          want = cmds_expected.pop_front();
          if (want.cmd.lin !== out_tdata[9:0]) begin
            $error("lin_speed: expected %0d, got %0d", want.cmd.lin, out_tdata[9:0]);
            mismatches++;
          end
          if (want.cmd.ang !== out_tdata[22:10]) begin
            $error("ang_speed: expected %0d, got %0d", want.cmd.ang,
                   $signed(out_tdata[22:10]));
            mismatches++;
          end
          if (want.cmd.cause !== out_tuser) begin
            $error("cause: expected %0d, got %0d", want.cmd.cause, out_tuser);
            mismatches++;
          end
          if (want.last !== out_tlast) begin
            $error("last_cmd: expected %0d, got %0d", want.last, out_tlast);
            mismatches++;
          end
        end
      end
    end
    cmds_due <= cmds_expected.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the wall-follow steering block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import lswfs_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [8:0] beam_index, [24:9] beam_range, [25] at_start
  logic [1:0]  in_tuser = '0;   // [0] op, [1] scan_first
  logic        in_tlast = 1'b0; // scan_last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [9:0] lin_speed, [22:10] ang_speed
  logic [2:0]  out_tuser;       // [2:0] cause
  logic        out_tlast;       // last_cmd
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  int fail_count;
  int cmds_due;

  // Idle rates in percent, long receiver hold request
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;

  // Thresholds as last written, used to aim ranges near them
  int st_range = 3500, st_safe = 100, st_follow = 300, st_warn = 600;

  laser_sector_wall_follow_steer dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  steer_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .cmds_due(cmds_due)
  );

  always #4 clk = ~clk;

  // Receiver: random stalls, plus one long hold on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic set_idle(input int tx, input int rx);
    tx_idle_pct = tx;
    rx_idle_pct <= rx;
  endtask

  // Offer one item, with random gaps ahead of it, and wait for the handshake
  task automatic push_item(input logic op, input logic [BW-1:0] idx,
                           input logic [RW-1:0] rng, input logic first,
                           input logic last, input logic start);
    while ($urandom_range(99) < tx_idle_pct) begin
      if (in_tvalid) in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, start, rng, idx};
    in_tuser  <= {first, op};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop offering, let all commands drain, then let trailing beams settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (cmds_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_settings(input logic [15:0] rl, input logic [15:0] sd,
                               input logic [15:0] fd, input logic [15:0] wd,
                               input logic [15:0] ml, input logic [15:0] ma);
    reg_write(REG_RANGE_LIMIT, rl);
    reg_write(REG_SAFE_DIST, sd);
    reg_write(REG_FOLLOW_DIST, fd);
    reg_write(REG_WARN_DIST, wd);
    reg_write(REG_MAX_LIN, ml);
    reg_write(REG_MAX_ANG, ma);
    cfg_valid <= 1'b0;
    st_range  = rl;
    st_safe   = sd;
    st_follow = fd;
    st_warn   = wd;
  endtask

  // Beam angle: mostly around a named sector, edges of its window included
  function automatic logic [BW-1:0] pick_beam();
    int s, off;
    if ($urandom_range(7) == 0) return BW'($urandom_range(511));
    case ($urandom_range(5))
      0: s = SEC_FRONT;
      1: s = SEC_LFRONT;
      2: s = SEC_LEFT;
      3: s = SEC_BACK;
      4: s = SEC_RIGHT;
      default: s = $urandom_range(NUM_SECTORS - 1);
    endcase
    off = int'($urandom_range(2 * HALF_BEAM + 1)) - HALF_BEAM - 1;
    return BW'((s * BEAMS_PER_SCAN / NUM_SECTORS + off + BEAMS_PER_SCAN) % BEAMS_PER_SCAN);
  endfunction

  // Range: mostly close to one of the thresholds
  function automatic logic [RW-1:0] pick_range();
    int v;
    case ($urandom_range(6))
      0: return RW'($urandom);
      1: v = st_safe;
      2: v = st_follow;
      3: v = st_warn;
      4: v = st_range;
      5: return RW'($urandom_range(1500));
      default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endcase
    v = v + int'($urandom_range(40)) - 20;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return RW'(v);
  endfunction

  // Short scans followed by ticks; some scans never publish, some items are noise
  task automatic run_traffic(input int n);
    int sent, nb, nt, shape, i;
    sent = 0;
    while (sent < n) begin
      shape = $urandom_range(9);
      if (shape == 0) begin
        push_item(1'($urandom_range(1)), BW'($urandom), RW'($urandom),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end else begin
        nb = $urandom_range(8, 1);
        for (i = 0; i < nb; i++)
          push_item(OP_BEAM, pick_beam(), pick_range(), i == 0,
                    (i == nb - 1) && (shape != 1), 1'($urandom_range(1)));
        nt = $urandom_range(2, 1);
        for (i = 0; i < nt; i++)
          push_item(OP_TICK, BW'($urandom), RW'($urandom), 1'b0, 1'b0,
                    $urandom_range(5) == 0);
        sent += nb + nt;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults; sender idles lightly, receiver heavily
    set_idle(15, 80);
    // tick before any scan: published distances are all zero
    push_item(OP_TICK, 9'd0, 16'd0, 1'b0, 1'b0, 1'b0);
    // scan with a gap beam, an out-of-range beam and range extremes
    push_item(OP_BEAM, 9'd0, 16'd1000, 1'b1, 1'b0, 1'b0);
    push_item(OP_BEAM, 9'd90, 16'd400, 1'b0, 1'b0, 1'b1);
    push_item(OP_BEAM, 9'd60, 16'd400, 1'b0, 1'b0, 1'b0);
    push_item(OP_BEAM, 9'd15, 16'd0, 1'b0, 1'b0, 1'b0);
    push_item(OP_BEAM, 9'd511, 16'd0, 1'b0, 1'b0, 1'b1);
    push_item(OP_BEAM, 9'd180, 16'd200, 1'b0, 1'b0, 1'b0);
    push_item(OP_BEAM, 9'd359, 16'hFFFF, 1'b0, 1'b1, 1'b0);
    push_item(OP_TICK, 9'h1FF, 16'hFFFF, 1'b0, 1'b0, 1'b1);
    // left far, clear ahead, rear obstacle with the right side wider
    push_item(OP_TICK, 9'd0, 16'd0, 1'b0, 1'b0, 1'b0);
    // left near, front warning, rear obstacle with the left side wider
    push_item(OP_BEAM, 9'd5, 16'd500, 1'b1, 1'b0, 1'b0);
    push_item(OP_BEAM, 9'd95, 16'd250, 1'b0, 1'b0, 1'b0);
    push_item(OP_BEAM, 9'd55, 16'd250, 1'b0, 1'b0, 1'b0);
    push_item(OP_BEAM, 9'd270, 16'd150, 1'b0, 1'b0, 1'b0);
    push_item(OP_BEAM, 9'd180, 16'd200, 1'b0, 1'b1, 1'b0);
    push_item(OP_TICK, 9'd0, 16'd0, 1'b0, 1'b0, 1'b0);
    // obstacle in a side sector wins over near start
    push_item(OP_BEAM, 9'd80, 16'd250, 1'b1, 1'b0, 1'b0);
    push_item(OP_BEAM, 9'd300, 16'd50, 1'b0, 1'b1, 1'b0);
    push_item(OP_TICK, 9'd0, 16'd0, 1'b0, 1'b0, 1'b1);
    // one-beam scan, left pair split: front step only
    push_item(OP_BEAM, 9'd80, 16'd250, 1'b1, 1'b1, 1'b0);
    push_item(OP_TICK, 9'd0, 16'd0, 1'b0, 1'b0, 1'b0);
    run_traffic(35);
    wait_drained();

    // Upper extremes; sender idles heavily, receiver lightly
    load_settings(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1000, 16'd4000);
    set_idle(80, 15);
    run_traffic(25);
    wait_drained();

    // Everything at zero, no idling
    load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    set_idle(0, 0);
    run_traffic(15);
    wait_drained();

    // Random settings; long receiver hold while items keep coming
    load_settings(16'($urandom_range(65535, 600)), 16'($urandom_range(200, 1)),
                  16'($urandom_range(800, 150)), 16'($urandom_range(1500, 300)),
                  16'($urandom_range(1000)), 16'($urandom_range(4000)));
    hold_req <= 1'b1;
    run_traffic(25);
    wait_drained();
    run_traffic(25);
    wait_drained();

    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
